[hw/rtl/lcdss_pkg.sv]
// Shared types and constants for the LCD command script sender.
package lcdss_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam logic [7:0] WAIT_LONG_CODE = 8'd255;
  localparam logic [8:0] WAIT_LONG_MS = 9'd500;

  // Configuration register indexes
  localparam logic [0:0] REG_DC_COMMAND = 1'b0;
  localparam logic [0:0] REG_DC_DATA = 1'b1;

  // Result kinds
  localparam logic KIND_BIT = 1'b0;
  localparam logic KIND_DELAY = 1'b1;

  typedef enum logic [3:0] {
    PH_CMD   = 4'b0001,
    PH_COUNT = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_WAIT  = 4'b1000
  } phase_t;

  // One unit of work for the serializer: a byte to shift out or a delay.
  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       dc;
    logic [8:0] wait_ms;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[hw/rtl/lcdss_ifs.sv]
// Channel interfaces: script input, result output, register write.
interface lcdss_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] script_byte;
  logic [7:0] command_total;
  modport source (output valid, req_type, script_byte, command_total, input ready);
  modport sink (input valid, req_type, script_byte, command_total, output ready);
endinterface

interface lcdss_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       serial_bit;
  logic       dc_line;
  logic [8:0] wait_ms;
  logic       last_of_run;
  modport source (output valid, result_kind, serial_bit, dc_line, wait_ms, last_of_run,
                  input ready);
  modport sink (input valid, result_kind, serial_bit, dc_line, wait_ms, last_of_run,
                output ready);
endinterface

interface lcdss_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [0:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/lcdss_front.sv]
// Front end: tracks the script phase, turns script bytes into serializer jobs.
module lcdss_front (
  input  logic                clk,
  input  logic                rst_n,
  lcdss_in_if.sink            in_ch,
  lcdss_cfg_if.sink           cfg_ch,
  input  lcdss_pkg::q_status_t q_stat,
  output logic                push,
  output lcdss_pkg::job_t     job
);
  import lcdss_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cmds_left_r, cmds_left_nxt;
  logic [7:0] data_left_r, data_left_nxt;
  logic       dc_cmd_r, dc_data_r;

  phase_t     ph_cur;
  logic [7:0] cl_cur;
  logic [7:0] dl_cur;
  logic [7:0] dl_dec;
  logic       take;
  logic       gen;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = !q_stat.full;
  assign take = in_ch.valid && in_ch.ready;
  assign dl_dec = dl_cur - 8'd1;

  always_comb begin
    ph_cur = in_ch.req_type ? PH_CMD : phase_r;
    cl_cur = in_ch.req_type ? in_ch.command_total : cmds_left_r;
    dl_cur = in_ch.req_type ? 8'd0 : data_left_r;
    phase_nxt = ph_cur;
    cmds_left_nxt = cl_cur;
    data_left_nxt = dl_cur;
    gen = 1'b0;
    job.kind = KIND_BIT;
    job.value = in_ch.script_byte;
    job.dc = dc_cmd_r;
    job.wait_ms = '0;
    if (cl_cur != 8'd0) begin
      case (ph_cur)
        PH_CMD: begin
          phase_nxt = PH_COUNT;
          gen = 1'b1;
        end
        PH_COUNT: begin
          data_left_nxt = in_ch.script_byte;
          phase_nxt = (in_ch.script_byte != 8'd0) ? PH_DATA : PH_WAIT;
        end
        PH_DATA: begin
          data_left_nxt = dl_dec;
          if (dl_dec == 8'd0) begin
            phase_nxt = PH_WAIT;
          end
          job.dc = dc_data_r;
          gen = 1'b1;
        end
        default: begin
          cmds_left_nxt = cl_cur - 8'd1;
          phase_nxt = PH_CMD;
          job.kind = KIND_DELAY;
          job.dc = 1'b0;
          job.wait_ms = (in_ch.script_byte == WAIT_LONG_CODE) ? WAIT_LONG_MS
                                                             : {1'b0, in_ch.script_byte};
          gen = (in_ch.script_byte != 8'd0);
        end
      endcase
    end
  end

  assign push = take && gen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      cmds_left_r <= '0;
      data_left_r <= '0;
      dc_cmd_r <= 1'b0;
      dc_data_r <= 1'b1;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        cmds_left_r <= cmds_left_nxt;
        data_left_r <= data_left_nxt;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DC_COMMAND: dc_cmd_r <= cfg_ch.data[0];
          REG_DC_DATA:    dc_data_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

[hw/rtl/lcdss_queue.sv]
// Short job queue between the front end and the serializer.
module lcdss_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lcdss_pkg::job_t      push_job,
  input  logic                 pop,
  output lcdss_pkg::job_t      head,
  output lcdss_pkg::q_status_t stat
);
  import lcdss_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign stat.full = (count_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hw/rtl/lcdss_back.sv]
// Back end: shifts bytes out MSB first and issues delay requests.
module lcdss_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdss_pkg::job_t      head,
  input  lcdss_pkg::q_status_t q_stat,
  output logic                 pop,
  lcdss_out_if.source          out_ch
);
  import lcdss_pkg::*;

  logic       busy_r;
  logic [6:0] shift_r;
  logic [2:0] cnt_r;
  logic       dc_r;

  logic       valid_r;
  logic       kind_r, bit_r, dcl_r, last_r;
  logic [8:0] delay_r;
  logic       adv;

  assign adv = !valid_r || out_ch.ready;
  assign pop = adv && !busy_r && !q_stat.empty;

  assign out_ch.valid = valid_r;
  assign out_ch.result_kind = kind_r;
  assign out_ch.serial_bit = bit_r;
  assign out_ch.dc_line = dcl_r;
  assign out_ch.wait_ms = delay_r;
  assign out_ch.last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      valid_r <= 1'b0;
      cnt_r <= '0;
    end else if (adv) begin
      if (busy_r) begin
        valid_r <= 1'b1;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end else if (!q_stat.empty) begin
        valid_r <= 1'b1;
        if (head.kind == KIND_BIT) begin
          busy_r <= 1'b1;
          cnt_r <= 3'd1;
        end
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  // Payload path, no reset needed
  always_ff @(posedge clk) begin
    if (adv) begin
      if (busy_r) begin
        kind_r <= KIND_BIT;
        bit_r <= shift_r[6];
        dcl_r <= dc_r;
        delay_r <= '0;
        last_r <= (cnt_r == 3'd7);
        shift_r <= {shift_r[5:0], 1'b0};
      end else if (!q_stat.empty) begin
        kind_r <= head.kind;
        last_r <= (head.kind == KIND_DELAY);
        delay_r <= head.wait_ms;
        dcl_r <= head.dc;
        bit_r <= (head.kind == KIND_BIT) ? head.value[7] : 1'b0;
        shift_r <= head.value[6:0];
        dc_r <= head.dc;
      end
    end
  end

endmodule

[hw/rtl/lcd_command_script_spi_sender.sv]
// Top level of the LCD command script sender.
// Script bytes are accepted one per request and classified at once by the front end;
// a command or data byte becomes eight serial-bit results (MSB first, one per cycle while
// the output is not stalled, last_of_run on the eighth), a nonzero wait byte one delay
// result (code 255 = 500 ms), and count bytes, zero waits and bytes past the script's
// command count give nothing. The serializer drains a two-entry job queue, so while a
// byte is still being shifted out the input side takes a new request every cycle until
// the queue fills; results are registered from the job at the queue head.
// Register writes (index 0: D/C level for commands, 1: D/C level for data) are taken
// every cycle and must only be made while the block is idle.
module lcd_command_script_spi_sender (
  input logic          clk,
  input logic          rst_n,
  lcdss_in_if.sink     in_ch,
  lcdss_out_if.source  out_ch,
  lcdss_cfg_if.sink    cfg_ch
);
  import lcdss_pkg::*;

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;
  q_status_t q_stat;

  lcdss_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_stat (q_stat),
    .push   (push),
    .job    (push_job)
  );

  lcdss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  lcdss_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

[hw/rtl/lcdss_checker.sv]
// Port-level checks for the LCD command script sender, bound to the top level.
module lcdss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic       serial_bit,
  input logic       dc_line,
  input logic [8:0] wait_ms,
  input logic       last_of_run
);
  import lcdss_pkg::*;

  // Output stays quiet right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_delay_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_DELAY |-> last_of_run)
    else $error("delay result not marked last");

  a_delay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_DELAY |->
      !serial_bit && !dc_line && wait_ms != 9'd0 && wait_ms <= WAIT_LONG_MS)
    else $error("malformed delay result");

  a_bit_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_BIT |-> wait_ms == 9'd0)
    else $error("serial bit carries a delay");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(serial_bit) && $stable(last_of_run))
    else $error("stalled result changed");

endmodule

bind lcd_command_script_spi_sender lcdss_checker u_lcdss_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_kind (out_ch.result_kind),
  .serial_bit  (out_ch.serial_bit),
  .dc_line     (out_ch.dc_line),
  .wait_ms     (out_ch.wait_ms),
  .last_of_run (out_ch.last_of_run)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the LCD command script sender: scripted and random scripts.
module tb;
  import lcdss_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic       kind;
    logic       sbit;
    logic       dc;
    logic [8:0] ms;
    logic       last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  lcdss_in_if  in_ch ();
  lcdss_out_if out_ch ();
  lcdss_cfg_if cfg_ch ();

  lcd_command_script_spi_sender u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  phase_t     script_phase;
  logic [7:0] cmds_left;
  logic [7:0] data_left;
  logic       dc_cmd;
  logic       dc_data;
  result_t    pending_results[$];

  int errors = 0;
  int in_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic void push_serial_byte(input logic [7:0] b, input logic dc);
    result_t r;
    for (int k = 7; k >= 0; k--) begin
      r.kind = KIND_BIT;
      r.sbit = b[k];
      r.dc   = dc;
      r.ms   = '0;
      r.last = (k == 0);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void predict_script_byte(input logic rt, input logic [7:0] b,
                                              input logic [7:0] tot);
    result_t r;
    if (rt) begin
      cmds_left    = tot;
      script_phase = PH_CMD;
      data_left    = '0;
    end
    if (cmds_left == 0) return;
    case (script_phase)
      PH_CMD: begin
        script_phase = PH_COUNT;
        push_serial_byte(b, dc_cmd);
      end
      PH_COUNT: begin
        data_left    = b;
        script_phase = (b != 0) ? PH_DATA : PH_WAIT;
      end
      PH_DATA: begin
        data_left = data_left - 8'd1;
        if (data_left == 0) script_phase = PH_WAIT;
        push_serial_byte(b, dc_data);
      end
      default: begin
        cmds_left    = cmds_left - 8'd1;
        script_phase = PH_CMD;
        if (b != 0) begin
          r.kind = KIND_DELAY;
          r.sbit = 1'b0;
          r.dc   = 1'b0;
          r.ms   = (b == WAIT_LONG_CODE) ? WAIT_LONG_MS : {1'b0, b};
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
    endcase
  endfunction

  task automatic send_script_byte(input logic rt, input logic [7:0] b, input logic [7:0] tot);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= rt;
    in_ch.script_byte   <= b;
    in_ch.command_total <= tot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_script_byte(rt, b, tot);
    in_count++;
  endtask

  // stop offering requests and let every expected result come out
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_DC_COMMAND) dc_cmd = val;
    else dc_data = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // well-formed script with random content; sometimes cut short or oversized
  task automatic send_random_script();
    int groups, ndata, cut, first;
    logic [7:0] wt;
    groups = ($urandom_range(7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 3);
    cut = ($urandom_range(4) == 0) ? $urandom_range(1, 8) : 1000;
    first = in_count;
    if (groups == 0) begin
      send_script_byte(1'b1, 8'($urandom), 8'd0);
      return;
    end
    for (int g = 0; g < groups && in_count - first < cut && in_count - first < 40; g++) begin
      ndata = ($urandom_range(5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      send_script_byte(g == 0, 8'($urandom), groups[7:0]);
      send_script_byte(1'b0, ndata[7:0], 8'($urandom));
      for (int d = 0; d < ndata && in_count - first < cut; d++)
        send_script_byte(1'b0, 8'($urandom), 8'($urandom));
      case ($urandom_range(3))
        0: wt = 8'd0;
        1: wt = WAIT_LONG_CODE;
        default: wt = 8'($urandom);
      endcase
      send_script_byte(1'b0, wt, 8'($urandom));
    end
    // trailing byte, dropped once the command count is used up
    if ($urandom_range(3) == 0) send_script_byte(1'b0, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed_script();
    // three groups: data extremes, zero count with zero wait, short wait code
    send_script_byte(1'b1, 8'h2A, 8'd3);
    send_script_byte(1'b0, 8'd2, 8'hFF);
    send_script_byte(1'b0, 8'hFF, 8'h00);
    send_script_byte(1'b0, 8'h00, 8'hFF);
    send_script_byte(1'b0, WAIT_LONG_CODE, 8'h00);
    send_script_byte(1'b0, 8'h00, 8'h00);
    send_script_byte(1'b0, 8'd0, 8'h00);
    send_script_byte(1'b0, 8'd0, 8'h00);
    send_script_byte(1'b0, 8'h80, 8'h00);
    send_script_byte(1'b0, 8'd1, 8'h00);
    send_script_byte(1'b0, 8'h01, 8'h00);
    send_script_byte(1'b0, 8'd254, 8'h00);
    // script used up
    send_script_byte(1'b0, 8'h55, 8'hAA);
    // new script with no commands
    send_script_byte(1'b1, 8'h11, 8'd0);
    send_script_byte(1'b0, 8'h22, 8'd0);
    // new script restarted in the middle of a group
    send_script_byte(1'b1, 8'hA5, 8'd255);
    send_script_byte(1'b0, 8'd3, 8'h00);
    send_script_byte(1'b0, 8'h5A, 8'h00);
    send_script_byte(1'b1, 8'h3C, 8'd1);
    send_script_byte(1'b0, 8'd0, 8'h00);
    send_script_byte(1'b0, 8'd1, 8'h00);
    send_script_byte(1'b0, 8'h77, 8'h00);
    drain();
  endtask

  task automatic test_register_settings();
    logic [1:0] combo;
    for (int i = 0; i < 4; i++) begin
      combo = i[1:0] ^ 2'b01;
      write_reg(REG_DC_COMMAND, combo[0]);
      write_reg(REG_DC_DATA, combo[1]);
      send_script_byte(1'b1, 8'($urandom), 8'd1);
      send_script_byte(1'b0, 8'd1, 8'h00);
      send_script_byte(1'b0, 8'($urandom), 8'h00);
      send_script_byte(1'b0, 8'd7, 8'h00);
      drain();
    end
    write_reg(REG_DC_COMMAND, 1'b0);
    write_reg(REG_DC_DATA, 1'b1);
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 150;
    send_script_byte(1'b1, 8'hC3, 8'd2);
    send_script_byte(1'b0, 8'd3, 8'h00);
    repeat (3) send_script_byte(1'b0, 8'($urandom), 8'h00);
    send_script_byte(1'b0, 8'd20, 8'h00);
    send_script_byte(1'b0, 8'h3A, 8'h00);
    send_script_byte(1'b0, 8'd2, 8'h00);
    repeat (2) send_script_byte(1'b0, 8'($urandom), 8'h00);
    send_script_byte(1'b0, WAIT_LONG_CODE, 8'h00);
    drain();
  endtask

  task automatic test_random_scripts();
    int gaps[4]   = '{0, 85, 0, 33};
    int stalls[4] = '{0, 0, 85, 33};
    int target;
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_DC_COMMAND, 1'($urandom_range(1)));
      write_reg(REG_DC_DATA, 1'($urandom_range(1)));
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      target = in_count + 35;
      while (in_count < target) begin
        if ($urandom_range(99) < 15)
          send_script_byte(1'($urandom_range(1)), 8'($urandom), 8'($urandom));
        else send_random_script();
      end
      drain();
    end
  endtask

  task automatic test_long_data_run();
    gap_pct = 0;
    stall_pct = 33;
    send_script_byte(1'b1, 8'h2C, 8'd1);
    send_script_byte(1'b0, 8'd40, 8'h00);
    repeat (40) send_script_byte(1'b0, 8'($urandom), 8'($urandom));
    send_script_byte(1'b0, WAIT_LONG_CODE, 8'h00);
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind=%0b bit=%0b dc=%0b ms=%0d last=%0b",
                 $time, out_ch.result_kind, out_ch.serial_bit, out_ch.dc_line,
                 out_ch.wait_ms, out_ch.last_of_run);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.kind, out_ch.result_kind);
        check_field("serial_bit", want.sbit, out_ch.serial_bit);
        check_field("dc_line", want.dc, out_ch.dc_line);
        check_field("wait_ms", want.ms, out_ch.wait_ms);
        check_field("last_of_run", want.last, out_ch.last_of_run);
      end
    end
  end

  // no handshake on any channel for too long means the block hung
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lcd_command_script_spi_sender verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = 1'b0;
    in_ch.script_byte   = '0;
    in_ch.command_total = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_DC_COMMAND;
    cfg_ch.data         = 1'b0;
    out_ch.ready        = 1'b0;
    script_phase        = PH_CMD;
    cmds_left           = '0;
    data_left           = '0;
    dc_cmd              = 1'b0;
    dc_data             = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_script();
    test_register_settings();
    test_backpressure();
    test_random_scripts();
    test_long_data_run();

    if (errors == 0) $display("lcd_command_script_spi_sender verification clean");
    else $display("lcd_command_script_spi_sender verification failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/lcdss_pkg.sv
hw/rtl/lcdss_ifs.sv
hw/rtl/lcdss_front.sv
hw/rtl/lcdss_queue.sv
hw/rtl/lcdss_back.sv
hw/rtl/lcd_command_script_spi_sender.sv
hw/rtl/lcdss_checker.sv
tb/sv/tb.sv
